// ===== rtl/fft_pkg.sv =====
// Shared constants and twiddle table for the radix-2 FFT engine.
package fft_pkg;

  localparam int MaxPointsDef = 64;
  localparam int TwFracDef    = 15;
  localparam int TableBits    = 24;
  localparam int DataW        = 32;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 3;

  localparam logic [CfgIdxW-1:0] RegLog2Points  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegInverseMode = 1'd1;

  // cos(k*pi/32) in Q.24, k = 0..16
  function automatic logic [24:0] cos_q24(input logic [4:0] k);
    logic [24:0] r;
    begin
      unique case (k)
        5'd0:  r = 25'd16777216;
        5'd1:  r = 25'd16696429;
        5'd2:  r = 25'd16454846;
        5'd3:  r = 25'd16054795;
        5'd4:  r = 25'd15500126;
        5'd5:  r = 25'd14796184;
        5'd6:  r = 25'd13949745;
        5'd7:  r = 25'd12968963;
        5'd8:  r = 25'd11863283;
        5'd9:  r = 25'd10643353;
        5'd10: r = 25'd9320922;
        5'd11: r = 25'd7908725;
        5'd12: r = 25'd6420363;
        5'd13: r = 25'd4870169;
        5'd14: r = 25'd3273072;
        5'd15: r = 25'd1644455;
        5'd16: r = 25'd0;
        default: r = 25'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/fft_stream_if.sv =====
// Valid/ready stream interface with a generic payload.
interface fft_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fft_twiddle.sv =====
// Twiddle generator: cosine and signed sine for angle index u of 64.
module fft_twiddle import fft_pkg::*; #(
  parameter int TwFrac = TwFracDef
) (
  input  logic [5:0]        u_i,
  input  logic              inverse_i,
  output logic signed [TwFrac+1:0] wr_o,
  output logic signed [TwFrac+1:0] wi_o
);
  localparam int Sh = TableBits - TwFrac;

  function automatic logic signed [TwFrac+1:0] mag(input logic [24:0] q);
    logic [25:0] t;
    begin
      if (Sh <= 0) t = {1'b0, q};
      else t = ({1'b0, q} + (26'd1 << (Sh - 1))) >> Sh;
      return $signed({1'b0, t[TwFrac:0]});
    end
  endfunction

  function automatic logic signed [TwFrac+1:0] cosf(input logic [5:0] v);
    begin
      if (v <= 6'd16) return mag(cos_q24(v[4:0]));
      else if (v <= 6'd32) return -mag(cos_q24(5'(6'd32 - v)));
      else if (v <= 6'd48) return -mag(cos_q24(5'(v - 6'd32)));
      else return mag(cos_q24(5'(7'd64 - {1'b0, v})));
    end
  endfunction

  logic signed [TwFrac+1:0] s;
  assign wr_o = cosf(u_i);
  assign s    = cosf(u_i + 6'd48);
  assign wi_o = inverse_i ? s : -s;
endmodule

// ===== rtl/fft_bfly.sv =====
// Pipelined butterfly: complex multiply, round, add/sub with saturation.
module fft_bfly import fft_pkg::*; #(
  parameter int TwFrac = TwFracDef
) (
  input  logic                     clk_i,
  input  logic signed [DataW-1:0]  ar_i,
  input  logic signed [DataW-1:0]  ai_i,
  input  logic signed [DataW-1:0]  xr_i,
  input  logic signed [DataW-1:0]  xi_i,
  input  logic signed [TwFrac+1:0] wr_i,
  input  logic signed [TwFrac+1:0] wi_i,
  output logic signed [DataW-1:0]  yr1_o,
  output logic signed [DataW-1:0]  yi1_o,
  output logic signed [DataW-1:0]  yr2_o,
  output logic signed [DataW-1:0]  yi2_o
);
  localparam int PW = DataW + TwFrac + 2;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [DataW-1:0] ar_q, ai_q;
  logic signed [SW-1:0] sr, si;
  logic signed [SW-TwFrac-1:0] tr, ti;
  logic signed [SW-TwFrac:0] s1r, s1i, s2r, s2i;

  always_ff @(posedge clk_i) begin
    p_rr_q <= PW'(wr_i) * PW'(xr_i);
    p_ii_q <= PW'(wi_i) * PW'(xi_i);
    p_ri_q <= PW'(wr_i) * PW'(xi_i);
    p_ir_q <= PW'(wi_i) * PW'(xr_i);
    ar_q   <= ar_i;
    ai_q   <= ai_i;
  end

  // floor(x + half) is an arithmetic shift after adding half
  assign sr = SW'(p_rr_q) - SW'(p_ii_q) + (SW'(1) <<< (TwFrac - 1));
  assign si = SW'(p_ri_q) + SW'(p_ir_q) + (SW'(1) <<< (TwFrac - 1));
  assign tr = sr[SW-1:TwFrac];
  assign ti = si[SW-1:TwFrac];
  assign s1r = (SW-TwFrac+1)'(ar_q) + (SW-TwFrac+1)'(tr);
  assign s1i = (SW-TwFrac+1)'(ai_q) + (SW-TwFrac+1)'(ti);
  assign s2r = (SW-TwFrac+1)'(ar_q) - (SW-TwFrac+1)'(tr);
  assign s2i = (SW-TwFrac+1)'(ai_q) - (SW-TwFrac+1)'(ti);

  function automatic logic signed [DataW-1:0] sat(input logic signed [SW-TwFrac:0] v);
    begin
      if (v > (SW-TwFrac+1)'(32'sh7fffffff)) return 32'sh7fffffff;
      else if (v < -(SW-TwFrac+1)'(33'sh080000000)) return 32'sh80000000;
      else return v[DataW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    yr1_o <= sat(s1r);
    yi1_o <= sat(s1i);
    yr2_o <= sat(s2r);
    yi2_o <= sat(s2i);
  end
endmodule

// ===== rtl/radix2_fft_engine.sv =====
// Radix-2 DIT FFT engine top level: load, butterfly sequencer, emit.
// Usage: configure log2_points (1..6) and inverse_mode through cfg_we_i /
// cfg_idx_i / cfg_data_i while idle; a write drops any partial frame.
// Samples enter on in_s (valid/ready); they are written in bit-reversed
// order straight into the working memory, one per cycle while ready is high.
// After the N-th sample the sequencer runs (N/2)*log2N butterflies one at a
// time: read A, read B, multiply, round/add/saturate, then two write-backs
// through the single write port of the memory. Then N bins leave in natural
// order on out_s, last_bin set on the final bin; each bin takes a memory read,
// then the output register, and the next read waits for it to land.
// Reset clears control and config (log2 6, forward); memory is not cleared.
// A stalled receiver holds the current bin in the output register and the
// sequencer waits; input ready stays low until the frame is fully emitted.
module radix2_fft_engine import fft_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef,
  parameter int TwFrac    = TwFracDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fft_stream_if.sink          in_s,
  fft_stream_if.source        out_s
);
  localparam int AW  = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  // largest power-of-two length that fits the memory
  localparam int LFit = $clog2(MaxPoints + 1) - 1;
  localparam int LMax = (LFit > 6) ? 6 : LFit;

  localparam logic [2:0] StLoad = 3'd0, StRdA = 3'd1, StRdB = 3'd2, StMul = 3'd3,
                         StWrA = 3'd4, StWrB = 3'd5, StEmit = 3'd6, StSum = 3'd7;

  logic [2:0] st_q, st_d;
  logic [2:0] log2_q;
  logic       inv_q;
  logic [2:0] l_eff;
  logic [AW:0] cnt_q, cnt_d;     // load/emit count
  logic [2:0] stage_q, stage_d;  // 1..l
  logic [AW-1:0] bf_q, bf_d;     // butterfly within stage
  logic [AW:0] npts;

  logic [DataW-1:0] mem_re [MaxPoints];
  logic [DataW-1:0] mem_im [MaxPoints];
  logic [DataW-1:0] rd_re_q, rd_im_q, a_re_q, a_im_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DataW-1:0] wre, wim;

  always_comb begin
    if (log2_q == 3'd0) l_eff = 3'd1;
    else if (log2_q > 3'(LMax)) l_eff = 3'(LMax);
    else l_eff = log2_q;
  end
  assign npts = (AW+1)'(1) << l_eff;

  // bit-reverse of load index over l_eff bits
  logic [AW-1:0] brev;
  always_comb begin
    brev = '0;
    for (int j = 0; j < AW; j++) begin
      if (j < int'(l_eff)) brev[int'(l_eff) - 1 - j] = cnt_q[j];
    end
  end

  // butterfly addresses: h = 2^(s-1), j = bf mod h, i1 = (bf/h)*2h + j
  logic [AW-1:0] hmask, jdx, i1, i2;
  logic [AW:0]   hval;
  logic [5:0]    tw_u;
  assign hval  = (AW+1)'(1) << (stage_q - 3'd1);
  assign hmask = AW'(hval - 1'b1);
  assign jdx   = bf_q & hmask;
  assign i1    = AW'((({1'b0, bf_q} & ~{1'b0, hmask}) << 1) | {1'b0, jdx});
  assign i2    = AW'({1'b0, i1} + hval);
  assign tw_u  = 6'(jdx) << (3'd6 - stage_q);

  logic signed [TwFrac+1:0] wr, wi;
  logic signed [DataW-1:0] y1r, y1i, y2r, y2i;
  fft_twiddle #(.TwFrac(TwFrac)) u_tw (
    .u_i(tw_u), .inverse_i(inv_q), .wr_o(wr), .wi_o(wi)
  );
  fft_bfly #(.TwFrac(TwFrac)) u_bf (
    .clk_i(clk_i), .ar_i(a_re_q), .ai_i(a_im_q), .xr_i(rd_re_q), .xi_i(rd_im_q),
    .wr_i(wr), .wi_i(wi), .yr1_o(y1r), .yi1_o(y1i), .yr2_o(y2r), .yi2_o(y2i)
  );

  // output register
  logic             ov_q, ov_d;
  logic [DataW-1:0] ore_q, oim_q;
  logic             olast_q;
  logic             emit_rd;
  logic             emit_rd_q;   // read issued last cycle
  logic [AW:0]      emit_idx_q;
  logic             in_acc;
  assign in_acc = in_s.valid && in_s.ready;
  assign in_s.ready = (st_q == StLoad) && !cfg_we_i;

  always_comb begin
    // B stays on the read port while the butterfly pipeline works on it
    we = 1'b0; waddr = brev; wre = DataW'(signed'(in_s.data.sample_real));
    wim = DataW'(signed'(in_s.data.sample_imag)); raddr = i2;
    st_d = st_q; cnt_d = cnt_q; stage_d = stage_q; bf_d = bf_q;
    unique case (st_q)
      StLoad: begin
        if (in_acc) begin
          we = 1'b1;
          if (cnt_q + 1'b1 == npts) begin
            cnt_d = '0; st_d = StRdA; stage_d = 3'd1; bf_d = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StRdA: begin raddr = i1; st_d = StRdB; end
      StRdB: begin raddr = i2; st_d = StMul; end
      StMul: st_d = StSum;
      StSum: st_d = StWrA;
      StWrA: begin
        we = 1'b1; waddr = i1; wre = y1r; wim = y1i; st_d = StWrB;
      end
      StWrB: begin
        we = 1'b1; waddr = i2; wre = y2r; wim = y2i; st_d = StRdA;
        if ({1'b0, bf_q} == (npts >> 1) - 1'b1) begin
          bf_d = '0;
          if (stage_q == l_eff) begin
            st_d = StEmit; cnt_d = '0;
          end else begin
            stage_d = stage_q + 3'd1;
          end
        end else begin
          bf_d = bf_q + 1'b1;
        end
      end
      StEmit: begin
        raddr = AW'(cnt_q);
        if (emit_rd) cnt_d = cnt_q + 1'b1;
        if (cnt_q == npts && !emit_rd_q && (!ov_q || out_s.ready)) begin
          st_d = StLoad; cnt_d = '0;
        end
      end
      default: st_d = StLoad;
    endcase
    if (cfg_we_i) begin
      st_d = StLoad; cnt_d = '0;
    end
  end

  // one read in flight at most, so a landing bin always finds the register free
  assign emit_rd = (st_q == StEmit) && !emit_rd_q && (!ov_q || out_s.ready) &&
                   (cnt_q != npts);
  assign ov_d = emit_rd_q ? 1'b1 : (ov_q && !out_s.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; cnt_q <= '0; stage_q <= 3'd1; bf_q <= '0;
      log2_q <= 3'd6; inv_q <= 1'b0; ov_q <= 1'b0; emit_rd_q <= 1'b0;
      emit_idx_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; stage_q <= stage_d; bf_q <= bf_d;
      ov_q <= ov_d; emit_rd_q <= emit_rd;
      if (emit_rd) emit_idx_q <= cnt_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegLog2Points:  log2_q <= cfg_data_i;
          RegInverseMode: inv_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_re[waddr] <= wre;
      mem_im[waddr] <= wim;
    end
    rd_re_q <= mem_re[raddr];
    rd_im_q <= mem_im[raddr];
    if (st_q == StRdB) begin
      a_re_q <= rd_re_q;
      a_im_q <= rd_im_q;
    end
    if (emit_rd_q) begin
      ore_q   <= rd_re_q;
      oim_q   <= rd_im_q;
      olast_q <= (emit_idx_q == npts - 1'b1);
    end
  end

  assign out_s.valid          = ov_q;
  assign out_s.data.bin_real  = ore_q;
  assign out_s.data.bin_imag  = oim_q;
  assign out_s.data.last_bin  = olast_q;
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the radix-2 FFT engine: random stimulus, transform prediction.
`timescale 1ns / 100ps

module tb import fft_pkg::*; ();

  typedef struct packed {
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] bin_real;
    logic signed [31:0] bin_imag;
    logic               last_bin;
  } bin_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  fft_stream_if #(.payload_t(sample_t)) in_if ();
  fft_stream_if #(.payload_t(bin_t))    out_if ();

  radix2_fft_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_if.sink),
    .out_s      (out_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // cos(k*pi/32) in Q.24
  localparam int CosQ24 [17] = '{16777216, 16696429, 16454846, 16054795, 15500126, 14796184,
                                 13949745, 12968963, 11863283, 10643353, 9320922, 7908725,
                                 6420363, 4870169, 3273072, 1644455, 0};

  sample_t     sample_queue[$];
  bin_t        bin_expect[$];
  longint      frame_re [64];
  longint      frame_im [64];
  int          load_cnt = 0;
  logic [2:0]  pred_log2 = 3'd6;
  logic        pred_inv = 1'b0;
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          bins_seen = 0;
  int          frames_done = 0;
  bit          idle_on = 1'b1;
  bit          hold_arm = 1'b0;
  int          hold_cycles = 0;

  function automatic longint tw_cos(int u);
    longint q;
    u = u & 63;
    if (u <= 16) q = CosQ24[u];
    else if (u <= 32) q = -CosQ24[32 - u];
    else if (u <= 48) q = -CosQ24[u - 32];
    else q = CosQ24[64 - u];
    // round magnitude from Q.24 down to Q.15
    if (q < 0) return -((-q + 256) >>> 9);
    return (q + 256) >>> 9;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int pts_log2();
    if (pred_log2 < 1) return 1;
    if (pred_log2 > 6) return 6;
    return pred_log2;
  endfunction

  function automatic void transform_frame(int l);
    int n, b, a, m, h, stp, i1, i2;
    longint t, wr, wi, tr, ti, ar, ai;
    n = 1 << l;
    for (int i = 0; i < n; i++) begin
      b = 0;
      a = i;
      for (int j = 0; j < l; j++) begin
        b = (b << 1) | (a & 1);
        a = a >> 1;
      end
      if (b > i) begin
        t = frame_re[i]; frame_re[i] = frame_re[b]; frame_re[b] = t;
        t = frame_im[i]; frame_im[i] = frame_im[b]; frame_im[b] = t;
      end
    end
    for (int s = 1; s <= l; s++) begin
      m = 1 << s;
      h = m >> 1;
      stp = 64 >> s;
      for (int k = 0; k < n; k += m) begin
        for (int j = 0; j < h; j++) begin
          i1 = k + j;
          i2 = i1 + h;
          wr = tw_cos(j * stp);
          wi = pred_inv ? tw_cos(j * stp + 48) : -tw_cos(j * stp + 48);
          tr = (wr * frame_re[i2] - wi * frame_im[i2] + 16384) >>> 15;
          ti = (wr * frame_im[i2] + wi * frame_re[i2] + 16384) >>> 15;
          ar = frame_re[i1];
          ai = frame_im[i1];
          frame_re[i1] = sat32(ar + tr);
          frame_im[i1] = sat32(ai + ti);
          frame_re[i2] = sat32(ar - tr);
          frame_im[i2] = sat32(ai - ti);
        end
      end
    end
  endfunction

  function automatic void accept_sample(sample_t smp);
    int l, n;
    bin_t b;
    l = pts_log2();
    n = 1 << l;
    if (load_cnt >= n) load_cnt = 0;
    frame_re[load_cnt] = smp.sample_real;
    frame_im[load_cnt] = smp.sample_imag;
    load_cnt++;
    if (load_cnt == n) begin
      transform_frame(l);
      for (int i = 0; i < n; i++) begin
        b.bin_real = frame_re[i][31:0];
        b.bin_imag = frame_im[i][31:0];
        b.last_bin = (i == n - 1);
        bin_expect.push_back(b);
      end
      load_cnt = 0;
      frames_done++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      send_gap    = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        accept_sample(in_if.data);
        sent_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_if.data  <= sample_queue.pop_front();
          in_if.valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int recv_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bin_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap     = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        bins_seen++;
        if (bin_expect.size() == 0) begin
          $display("%0t: unexpected bin %p", $time, out_if.data);
          err_cnt++;
        end else begin
          want = bin_expect.pop_front();
          if (want.bin_real !== out_if.data.bin_real) begin
            $display("%0t: bin_real expected %0d actual %0d", $time, want.bin_real,
                     out_if.data.bin_real);
            err_cnt++;
          end
          if (want.bin_imag !== out_if.data.bin_imag) begin
            $display("%0t: bin_imag expected %0d actual %0d", $time, want.bin_imag,
                     out_if.data.bin_imag);
            err_cnt++;
          end
          if (want.last_bin !== out_if.data.last_bin) begin
            $display("%0t: last_bin expected %0b actual %0b", $time, want.last_bin,
                     out_if.data.last_bin);
            err_cnt++;
          end
        end
      end
      // long stall starts once bins show up
      if (hold_arm && out_if.valid) begin
        hold_arm = 1'b0;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegLog2Points) pred_log2 = val;
    else pred_inv = val[0];
    load_cnt = 0;
  endtask

  task automatic drain();
    while (sample_queue.size() > 0 || in_if.valid || bin_expect.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic setup(int l2, bit inv);
    drain();
    write_reg(RegLog2Points, l2[2:0]);
    write_reg(RegInverseMode, {2'b00, inv});
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    int r;
    r = $urandom_range(0, 9);
    s.sample_real = $urandom();
    s.sample_imag = $urandom();
    if (r == 0) s.sample_real = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if (r == 1) s.sample_imag = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return s;
  endfunction

  task automatic push_pair(logic [15:0] re, logic [15:0] im);
    sample_t s;
    s.sample_real = re;
    s.sample_imag = im;
    sample_queue.push_back(s);
  endtask

  initial begin
    int l2, n, cnt, phase;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes at two points, both directions, length zero clamp
    setup(1, 1'b0);
    push_pair(16'h7fff, 16'h7fff); push_pair(16'h8000, 16'h8000);
    push_pair(16'h8000, 16'h7fff); push_pair(16'h7fff, 16'h8000);
    setup(1, 1'b1);
    push_pair(16'h8000, 16'h0000); push_pair(16'h7fff, 16'hffff);
    setup(0, 1'b0);
    push_pair(16'h0001, 16'h8000); push_pair(16'h0000, 16'h7fff);
    // partial frame dropped by a config write
    setup(2, 1'b0);
    push_pair(16'h1234, 16'h4321); push_pair(16'h8000, 16'h8000);
    push_pair(16'h7fff, 16'h7fff);
    setup(3, 1'b1);
    for (int i = 0; i < 8; i++) sample_queue.push_back(rand_sample());

    phase = 0;
    while (sent_cnt + sample_queue.size() < 460) begin
      case ($urandom_range(0, 11))
        0: l2 = 0;
        1: l2 = 7;
        2: l2 = 6;
        3: l2 = 5;
        default: l2 = $urandom_range(1, 4);
      endcase
      setup(l2, $urandom_range(0, 1));
      idle_on = ($urandom_range(0, 3) != 0);
      n = 1 << ((l2 < 1) ? 1 : (l2 > 6) ? 6 : l2);
      cnt = n * $urandom_range(1, (n >= 32) ? 1 : 3);
      if ($urandom_range(0, 4) == 0) cnt += $urandom_range(1, n - 1);
      // long receiver stall while the sender keeps offering the next frame
      if (phase == 2) begin
        hold_arm = 1'b1;
        cnt += n;
      end
      phase++;
      for (int i = 0; i < cnt; i++) sample_queue.push_back(rand_sample());
    end
    drain();

    $display("Sent %0d samples in %0d frames over %0d phases; %0d bins checked.",
             sent_cnt, frames_done, phase, bins_seen);
    if (err_cnt == 0 && bin_expect.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
